/* hdl/glyph_code_binary_search_top_assert.svh */
// ----------------------------------------------------------------------------
// glyph_code_binary_search_top_assert.svh
// Assertion macros shared by the glyph code search block.
// ----------------------------------------------------------------------------
`ifndef GLYPH_CODE_BINARY_SEARCH_TOP_ASSERT_SVH
`define GLYPH_CODE_BINARY_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define GCBS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcbs check failed: same-cycle rule");

// Next-cycle implication, checked on every rising clk edge outside reset.
`define GCBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcbs check failed: next-cycle rule");

`endif

/* hdl/gcbs_pkg.sv */
// ----------------------------------------------------------------------------
// gcbs_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package gcbs_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CODE_W      = 16;
  localparam int SLOT_W      = 12;
  localparam int CNT_W       = 13;
  localparam int IDX_W       = 12;
  localparam int PTR_W       = CNT_W + 1;  // signed search bounds, hi may reach -1
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_INDEX = 1'd1;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Commands from controller to datapath.
  typedef struct packed {
    logic init;   // load bounds and query
    logic probe;  // hold the probed slot
    logic step;   // narrow the bounds after a compare
    logic hit;    // record the probed slot as result
    logic miss;   // record the fallback as result
  } gcbs_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic empty;  // search range exhausted
    logic hit;    // probed code equals query
  } gcbs_stat_t;

endpackage

`default_nettype wire

/* hdl/gcbs_ram.sv */
// ----------------------------------------------------------------------------
// gcbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gcbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/gcbs_dp.sv */
// ----------------------------------------------------------------------------
// gcbs_dp
// Search datapath: bounds, midpoint, code compare and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gcbs_dp
  import gcbs_pkg::*;
(
  input  wire logic              clk,
  input  wire gcbs_cmd_t         cmd,
  output gcbs_stat_t             stat,
  input  wire logic [CODE_W-1:0] query_code,
  input  wire logic [CNT_W-1:0]  tile_count,
  input  wire logic [IDX_W-1:0]  fallback_index,
  input  wire logic [CODE_W-1:0] rdata,
  output logic      [ADDR_W-1:0] raddr,
  output logic      [IDX_W-1:0]  glyph_index,
  output logic                   found
);

  logic signed [PTR_W-1:0] lo;
  logic signed [PTR_W-1:0] hi;
  logic signed [PTR_W-1:0] mid;
  logic signed [PTR_W-1:0] mid_ext;
  logic        [CNT_W-1:0] n_clamp;
  logic        [ADDR_W-1:0] mid_q;
  logic        [CODE_W-1:0] query;

  // Clamp an oversized count to the table depth.
  assign n_clamp = (tile_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : tile_count;

  assign mid     = lo + ((hi - lo) >>> 1);
  assign raddr   = mid[ADDR_W-1:0];
  assign mid_ext = signed'(PTR_W'(mid_q));

  assign stat.empty = (lo > hi);
  assign stat.hit   = (rdata == query);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      lo    <= '0;
      hi    <= signed'(PTR_W'(n_clamp)) - PTR_W'(1);
      query <= query_code;
    end else if (cmd.step) begin
      if (rdata < query) begin
        lo <= mid_ext + PTR_W'(1);
      end else begin
        hi <= mid_ext - PTR_W'(1);
      end
    end
    if (cmd.probe) begin
      mid_q <= mid[ADDR_W-1:0];
    end
    if (cmd.hit) begin
      glyph_index <= IDX_W'(mid_q);
      found       <= 1'b1;
    end else if (cmd.miss) begin
      glyph_index <= fallback_index;
      found       <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hdl/gcbs_ctrl.sv */
// ----------------------------------------------------------------------------
// gcbs_ctrl
// Search controller: accepts requests and sequences probe/compare steps.
// ----------------------------------------------------------------------------
`default_nettype none

module gcbs_ctrl
  import gcbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       mode,
  input  wire gcbs_stat_t stat,
  output gcbs_cmd_t       cmd,
  output logic            busy,
  output logic            done
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE
  } state_t;

  state_t state;
  logic   accept_lookup;

  assign accept_lookup = start && !busy && (mode == MODE_LOOKUP);

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.init = accept_lookup;
      end
      ST_PROBE: begin
        cmd.miss  = stat.empty;
        cmd.probe = !stat.empty;
      end
      ST_COMPARE: begin
        cmd.hit  = stat.hit;
        cmd.step = !stat.hit;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept_lookup) begin
            state <= ST_PROBE;
            busy  <= 1'b1;
          end
        end
        ST_PROBE: begin
          if (stat.empty) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            state <= ST_COMPARE;
          end
        end
        ST_COMPARE: begin
          if (stat.hit) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            state <= ST_PROBE;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/glyph_code_binary_search_top.sv */
// ----------------------------------------------------------------------------
// glyph_code_binary_search_top
// Character code to glyph index lookup by binary search over a sorted
// code table held in on-chip RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ---------------------------------------
//   request   start, accepted when   mode, entry_slot, entry_code,
//             busy is low            query_code
//   result    done strobe, 1 cycle   glyph_index, found
//   config    cfg_we, no wait        cfg_addr, cfg_wdata
//
// A load request writes the code RAM at the accepting edge; it returns no
// result and busy stays low.
// A lookup request steps through a probe state, which addresses the
// registered read port of the code RAM, and a compare state per probe; a
// miss ends in the probe state once the range is empty, a hit ends in the
// compare state.
// A new request is taken in the same cycle that done is shown.
// Reset clears the controller and both configuration registers; the code
// RAM is not cleared, so only slots already written may be searched.
// The receiver cannot stall: each result is valid for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_code_binary_search_top
  import gcbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  mode,
  input  wire logic [SLOT_W-1:0]     entry_slot,
  input  wire logic [CODE_W-1:0]     entry_code,
  input  wire logic [CODE_W-1:0]     query_code,
  // result
  output logic                       done,
  output logic      [IDX_W-1:0]      glyph_index,
  output logic                       found,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0]  tile_count;
  logic [IDX_W-1:0]  fallback_index;
  gcbs_cmd_t         cmd;
  gcbs_stat_t        stat;
  logic              ram_we;
  logic [ADDR_W-1:0] raddr;
  logic [CODE_W-1:0] rdata;

  // Configuration registers; the user must write them only while no lookup is in flight, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_count     <= '0;
      fallback_index <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TILE_COUNT: begin
          tile_count <= cfg_wdata[CNT_W-1:0];
        end
        REG_FALLBACK_INDEX: begin
          fallback_index <= cfg_wdata[IDX_W-1:0];
        end
        default: begin
          tile_count <= tile_count;
        end
      endcase
    end
  end

  // Write the table on an accepted load request; drop slots past the depth.
  assign ram_we = start && !busy && (mode == MODE_LOAD)
                  && (int'(entry_slot) < TABLE_DEPTH);

  gcbs_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_code_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(entry_slot)),
    .wdata (entry_code),
    .raddr (raddr),
    .rdata (rdata)
  );

  gcbs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  gcbs_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .stat           (stat),
    .query_code     (query_code),
    .tile_count     (tile_count),
    .fallback_index (fallback_index),
    .rdata          (rdata),
    .raddr          (raddr),
    .glyph_index    (glyph_index),
    .found          (found)
  );

  `include "glyph_code_binary_search_top_assert.svh"

  // A result is only shown once the controller is back to accepting requests.
  `GCBS_ASSERT_SAME(a_done_not_busy, done, !busy)
  // An accepted lookup always occupies the controller the next cycle.
  `GCBS_ASSERT_NEXT(a_lookup_busy, start && !busy && (mode == MODE_LOOKUP), busy)
  // A load request never starts a search or produces a result.
  `GCBS_ASSERT_NEXT(a_load_silent, start && !busy && (mode == MODE_LOAD), !busy && !done)
  // Result strobe lasts exactly one cycle.
  `GCBS_ASSERT_NEXT(a_done_pulse, done, !done)

endmodule

`default_nettype wire

/* tb/sv/glyph_search_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_search_checker
// Watches the request, result and configuration ports of the glyph code
// search block. Keeps its own copy of the code table and registers, predicts
// each lookup and compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module glyph_search_checker
  import gcbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  mode,
  input  logic [SLOT_W-1:0]     entry_slot,
  input  logic [CODE_W-1:0]     entry_code,
  input  logic [CODE_W-1:0]     query_code,
  input  logic                  done,
  input  logic [IDX_W-1:0]      glyph_index,
  input  logic                  found,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_count,
  output int                    hit_count,
  output int                    miss_count
);

  typedef struct packed {
    logic [IDX_W-1:0] glyph_index;
    logic             found;
  } glyph_result_t;

  logic [CODE_W-1:0] code_shadow [TABLE_DEPTH];
  logic [CNT_W-1:0]  tile_count_q;
  logic [IDX_W-1:0]  fallback_q;
  glyph_result_t     expected_glyphs [$];
  int                fails  = 0;
  int                hits   = 0;
  int                misses = 0;

  // Halving search over the valid slots; a count above the depth is clamped.
  function automatic glyph_result_t search_codes(input logic [CODE_W-1:0] key);
    int            lo;
    int            hi;
    int            mid;
    glyph_result_t res;
    lo = 0;
    hi = (tile_count_q > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(tile_count_q) - 1;
    res.glyph_index = fallback_q;
    res.found       = 1'b0;
    while (lo <= hi && !res.found) begin
      mid = lo + (hi - lo) / 2;
      if (code_shadow[mid] == key) begin
        res.glyph_index = mid[IDX_W-1:0];
        res.found       = 1'b1;
      end else if (code_shadow[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    glyph_result_t want;
    if (rst) begin
      tile_count_q = '0;
      fallback_q   = '0;
      expected_glyphs.delete();
    end else begin
      // Retire the result first so a request taken at the same edge queues behind it.
      if (done) begin
        if (expected_glyphs.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual glyph_index %0d found %0b",
                   $time, glyph_index, found);
          fails++;
        end else begin
          want = expected_glyphs.pop_front();
          if (want.found) hits++;
          else misses++;
          if (glyph_index !== want.glyph_index) begin
            $display("%0t: glyph_index mismatch: expected %0d, actual %0d",
                     $time, want.glyph_index, glyph_index);
            fails++;
          end
          if (found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, found);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        if (mode == MODE_LOAD) code_shadow[entry_slot] = entry_code;
        else expected_glyphs.push_back(search_codes(query_code));
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_TILE_COUNT:     tile_count_q = cfg_wdata[CNT_W-1:0];
          REG_FALLBACK_INDEX: fallback_q   = cfg_wdata[IDX_W-1:0];
          default: ;
        endcase
      end
    end
    pending_count <= expected_glyphs.size();
    fail_count    <= fails;
    hit_count     <= hits;
    miss_count    <= misses;
  end

endmodule

/* tb/sv/tb_glyph_code_binary_search_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_code_binary_search_top
// Drives load and lookup requests and register writes into the glyph code
// search block; a checker beside it predicts and compares each result. A
// directed pass hits the table edges, empty and clamped counts and an
// unsorted table, then random phases mix ordered loads and lookups under
// several request gap rates and register settings.
// ----------------------------------------------------------------------------
module tb_glyph_code_binary_search_top;
  import gcbs_pkg::*;

  localparam int QUIET_LIMIT   = 2000; // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 32;   // idle wait after the last result
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 64;   // requests per random phase

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  start      = 1'b0;
  logic                  mode       = MODE_LOAD;
  logic [SLOT_W-1:0]     entry_slot = '0;
  logic [CODE_W-1:0]     entry_code = '0;
  logic [CODE_W-1:0]     query_code = '0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = REG_TILE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  busy;
  logic                  done;
  logic [IDX_W-1:0]      glyph_index;
  logic                  found;

  int fail_count;
  int pending_count;
  int hit_count;
  int miss_count;
  int quiet_cycles  = 0;
  int idle_pct      = 0;  // chance per cycle that the sender holds off
  int span          = 0;  // slots the block will search under the current count
  int loads_sent    = 0;
  int lookups_sent  = 0;
  int settings_used = 0;

  // Stimulus-side copy of the table, used to aim lookups at stored codes.
  // Unwritten slots hold an ascending code, sent as is when a search first probes them.
  logic [CODE_W-1:0] slot_codes   [TABLE_DEPTH];
  bit                slot_written [TABLE_DEPTH];

  glyph_code_binary_search_top u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .entry_slot  (entry_slot),
    .entry_code  (entry_code),
    .query_code  (query_code),
    .done        (done),
    .glyph_index (glyph_index),
    .found       (found),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata)
  );

  glyph_search_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .entry_slot    (entry_slot),
    .entry_code    (entry_code),
    .query_code    (query_code),
    .done          (done),
    .glyph_index   (glyph_index),
    .found         (found),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .hit_count     (hit_count),
    .miss_count    (miss_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Count cycles in which nothing moves on any port; a hang ends the run.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL glyph_code_binary_search_top");
    $finish;
  end

  // Present one request and hold it until the block takes it. Start stays
  // high afterwards so back-to-back requests need no second assignment.
  task automatic send_request(input logic req_mode, input logic [SLOT_W-1:0] slot,
                              input logic [CODE_W-1:0] ecode,
                              input logic [CODE_W-1:0] qcode);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    mode       <= req_mode;
    entry_slot <= slot;
    entry_code <= ecode;
    query_code <= qcode;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_slot(input logic [SLOT_W-1:0] slot, input logic [CODE_W-1:0] code);
    slot_codes[slot]   = code;
    slot_written[slot] = 1'b1;
    loads_sent++;
    send_request(MODE_LOAD, slot, code, CODE_W'($urandom_range(65535, 0)));
  endtask

  // Walk the probes the coming search will make and load any slot on that
  // path that was never written, so the block only reads written slots.
  task automatic cover_path(input logic [CODE_W-1:0] key);
    int lo;
    int hi;
    int mid;
    bit hit;
    lo  = 0;
    hi  = span - 1;
    hit = 1'b0;
    while (lo <= hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (!slot_written[mid]) load_slot(SLOT_W'(mid), slot_codes[mid]);
      if (slot_codes[mid] == key) hit = 1'b1;
      else if (slot_codes[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
  endtask

  task automatic lookup(input logic [CODE_W-1:0] key);
    cover_path(key);
    lookups_sent++;
    send_request(MODE_LOOKUP, SLOT_W'($urandom_range(TABLE_DEPTH - 1, 0)),
                 CODE_W'($urandom_range(65535, 0)), key);
  endtask

  // Drop start, wait for every predicted result, then let the block go quiet.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the block idle and nothing outstanding.
  task automatic apply_setting(input int tiles, input int fallback);
    settle();
    write_reg(REG_TILE_COUNT, tiles[CFG_DATA_W-1:0]);
    write_reg(REG_FALLBACK_INDEX, fallback[CFG_DATA_W-1:0]);
    span = (tiles > TABLE_DEPTH) ? TABLE_DEPTH : tiles;
    settings_used++;
  endtask

  // Mostly small tables, a few deep searches, some empty and clamped counts.
  function automatic int pick_tile_count();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 10) return 0;
    if (roll < 40) return $urandom_range(16, 1);
    if (roll < 80) return $urandom_range(256, 17);
    if (roll < 90) return $urandom_range(TABLE_DEPTH, 257);
    if (roll < 95) return TABLE_DEPTH;
    return $urandom_range(8191, TABLE_DEPTH + 1);
  endfunction

  // One random request: ordered loads inside the searched range, a little
  // unordered noise, and lookups aimed at stored codes, their neighbors,
  // random codes and the code extremes.
  task automatic random_request();
    int               roll;
    int               slot;
    int               lo_b;
    int               hi_b;
    logic [CODE_W-1:0] key;
    roll = $urandom_range(99, 0);
    if (roll < 25) begin
      slot = (span > 0) ? $urandom_range(span - 1, 0) : $urandom_range(TABLE_DEPTH - 1, 0);
      lo_b = (slot > 0) ? int'(slot_codes[slot - 1]) : 0;
      hi_b = (slot < TABLE_DEPTH - 1) ? int'(slot_codes[slot + 1]) : 65535;
      // keep ascending order between the two neighbors when they allow it
      if (lo_b <= hi_b) load_slot(SLOT_W'(slot), CODE_W'($urandom_range(hi_b, lo_b)));
      else load_slot(SLOT_W'(slot), CODE_W'($urandom_range(65535, 0)));
    end else if (roll < 28) begin
      load_slot(SLOT_W'($urandom_range(TABLE_DEPTH - 1, 0)), CODE_W'($urandom_range(65535, 0)));
    end else begin
      roll = $urandom_range(99, 0);
      slot = (span > 0) ? $urandom_range(span - 1, 0) : 0;
      if (roll < 50) key = slot_codes[slot];
      else if (roll < 70) key = slot_codes[slot] + (roll[0] ? 16'h0001 : 16'hFFFF);
      else if (roll < 90) key = CODE_W'($urandom_range(65535, 0));
      else key = roll[0] ? 16'hFFFF : 16'h0000;
      lookup(key);
    end
  endtask

  initial begin : stimulus
    int phase;
    int n;
    int base;
    // Ascending codes for every slot; an unwritten slot is sent when a search first probes it.
    for (n = 0; n < TABLE_DEPTH; n++) slot_codes[n] = CODE_W'(n * 16 + 8);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table straight out of reset: no slot is probed, so the
    // unwritten RAM is never read.
    lookup(16'h0000);
    lookup(16'hFFFF);
    apply_setting(0, 4095);
    lookup(16'h1234);

    // Code extremes at the table edges, full-depth searches.
    load_slot(0, 16'h0000);
    load_slot(SLOT_W'(TABLE_DEPTH - 1), 16'hFFFF);
    apply_setting(TABLE_DEPTH, $urandom_range(4095, 0));
    lookup(16'h0000);
    lookup(16'hFFFF);
    lookup(slot_codes[TABLE_DEPTH / 2]);
    lookup(16'h0001);
    lookup(slot_codes[1234] + 16'h0001);

    // Count beyond the depth is clamped to the full table.
    apply_setting(8191, 0);
    lookup(16'hFFFF);
    lookup(16'h8009);

    // Single-entry table.
    apply_setting(1, 4095);
    lookup(16'h0000);
    lookup(16'h0005);

    // Unsorted table: the search keeps its probe order and reports what it meets.
    apply_setting(7, $urandom_range(4095, 0));
    load_slot(3, 16'hFFFF);
    lookup(slot_codes[5]);
    lookup(slot_codes[1]);
    load_slot(3, 16'd56);

    // Random phases. Gap rates cycle through none, heavy, none and light;
    // the result side cannot stall, so its stall phase runs without gaps.
    // Each new setting waits for all results first.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_pct = 0;
      apply_setting(pick_tile_count(),
                    (phase % 3 == 0) ? ((phase % 2 == 1) ? 4095 : 0) : $urandom_range(4095, 0));
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 49;
        2: idle_pct = 0;
        default: idle_pct = 22;
      endcase
      base = loads_sent + lookups_sent;
      while (loads_sent + lookups_sent - base < PHASE_ITEMS) random_request();
    end

    idle_pct = 0;
    settle();
    $display("Covered %0d loads and %0d lookups (%0d hits, %0d misses) under %0d settings.",
             loads_sent, lookups_sent, hit_count, miss_count, settings_used);
    $display("Directed edges, empty and clamped counts, unsorted table, then random phases.");
    if (fail_count == 0) $display("PASS glyph_code_binary_search_top");
    else $display("FAIL glyph_code_binary_search_top");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/gcbs_pkg.sv
hdl/gcbs_ram.sv
hdl/gcbs_dp.sv
hdl/gcbs_ctrl.sv
hdl/glyph_code_binary_search_top.sv
tb/sv/glyph_search_checker.sv
tb/sv/tb_glyph_code_binary_search_top.sv
